FILE: hdl/gaussian_mixture_label_sampler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian mixture label sampler
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_MIXTURE_LABEL_SAMPLER_MACROS_SVH
`define GAUSSIAN_MIXTURE_LABEL_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gmls_pkg.sv
// ----------------------------------------------------------------------------
// gmls_pkg
// Types, codes and the Gaussian table generator for the label sampler.
// ----------------------------------------------------------------------------
package gmls_pkg;

  localparam int DIV_REM_W  = 32;
  localparam int DIV_BITS_W = 41;
  localparam int DIV_CNT_W  = 6;
  localparam int RATE_W     = 41;
  localparam int TOTAL_W    = 44;
  localparam int THRESH_W   = 60;
  localparam int EXP_W      = 17;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic CFG_ACTIVE   = 1'b0;
  localparam logic CFG_INACTIVE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [2:0]         entry_index;
    logic [15:0]        entry_weight;
    logic signed [31:0] entry_mean;
    logic [31:0]        entry_sigma;
    logic [15:0]        entry_count;
    logic signed [31:0] sample_value;
    logic [2:0]         old_label;
    logic [15:0]        uniform_draw;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  new_label;
    logic [15:0] new_label_count;
    logic        zero_total;
    logic        sweep_done;
  } out_item_t;

  typedef struct packed {
    logic [3:0] active;
    logic [2:0] inactive;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem0;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_CNT_W-1:0]  steps;
    logic [31:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_BITS_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_IDX, ST_IDX_WAIT, ST_MUL, ST_RATE, ST_RATE_WAIT,
    ST_THRESH, ST_PICK, ST_DEC, ST_INC, ST_FIN
  } back_state_t;

  // exp(-f) in Q30 for f in [0, 1] (Q30), truncated series; elaboration only.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if ((k % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Table entry exp(-x^2/2) in Q1.16 for x = i * 8 / 2^bits.
  function automatic logic [EXP_W-1:0] gauss_entry(input int i, input int bits);
    logic [63:0] e1;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] r;
    e1 = exp_neg_q30(64'd1 << 30);
    a  = (64'(i) * 64'(i)) << (35 - 2 * bits);
    n  = a >> 30;
    r  = exp_neg_q30(a & ((64'd1 << 30) - 64'd1));
    for (int j = 0; j < 64; j++) begin
      if (64'(j) < n) r = (r * e1) >> 30;
    end
    return EXP_W'((r + 64'd8192) >> 14);
  endfunction

endpackage

FILE: hdl/gmls_div.sv
// ----------------------------------------------------------------------------
// gmls_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module gmls_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gmls_pkg::div_req_t  req,
  output gmls_pkg::div_rsp_t  rsp
);
  import gmls_pkg::*;

  logic [DIV_REM_W-1:0]  rem_r, rem_nxt;
  logic [DIV_BITS_W-1:0] bits_r, bits_nxt;
  logic [DIV_BITS_W-1:0] q_r, q_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]           dvs_r, dvs_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_REM_W:0]    trial;
  logic [DIV_REM_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, bits_r[DIV_BITS_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem0;
      bits_nxt = req.bits;
      q_nxt    = '0;
      cnt_nxt  = req.steps;
      dvs_nxt  = req.divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      bits_nxt = {bits_r[DIV_BITS_W-2:0], 1'b0};
      q_nxt    = {q_r[DIV_BITS_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    q_r    <= q_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

FILE: hdl/gmls_front.sv
// ----------------------------------------------------------------------------
// gmls_front
// Input side: accepts beats into a two-entry queue for the sampling engine.
// ----------------------------------------------------------------------------
module gmls_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gmls_pkg::in_item_t  in_data,
  output logic                q_valid,
  output gmls_pkg::in_item_t  q_item,
  input  logic                q_take
);
  import gmls_pkg::*;

  in_item_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= in_data;
  end

endmodule

FILE: hdl/gmls_back.sv
// ----------------------------------------------------------------------------
// gmls_back
// Sampling engine: component table, per-component scoring, label pick,
// count update and the result register.
// ----------------------------------------------------------------------------
module gmls_back #(
  parameter int MAX_COMPONENTS = 8,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gmls_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  gmls_pkg::in_item_t  q_item,
  output logic                q_take,
  output gmls_pkg::div_req_t  div_req,
  input  gmls_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output gmls_pkg::out_item_t out_data
);
  import gmls_pkg::*;

  localparam int TABLE_CAP = (MAX_COMPONENTS < 8) ? MAX_COMPONENTS : 8;
  localparam int CIDX_W    = $clog2(TABLE_CAP);
  localparam int EXP_SIZE  = 1 << EXP_TABLE_BITS;

  logic [EXP_W-1:0] exp_tab [EXP_SIZE];
  for (genvar g = 0; g < EXP_SIZE; g++) begin : g_tab
    assign exp_tab[g] = gauss_entry(g, EXP_TABLE_BITS);
  end

  logic [15:0]        weight_r [TABLE_CAP];
  logic signed [31:0] mean_r   [TABLE_CAP];
  logic [31:0]        sigma_r  [TABLE_CAP];
  logic [15:0]        count_r  [TABLE_CAP];
  logic [RATE_W-1:0]  rate_r   [TABLE_CAP];

  back_state_t         state_r, state_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [3:0]          used_r, used_nxt;
  logic signed [31:0]  y_r;
  logic [2:0]          old_r;
  logic [15:0]         draw_r;
  logic                last_r;
  logic [32:0]         ad_r, ad_nxt;
  logic [EXP_TABLE_BITS-1:0] idx_r, idx_nxt;
  logic [32:0]         prod_r, prod_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [TOTAL_W-1:0]  cum_r, cum_nxt;
  logic [THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [2:0]          label_r, label_nxt;
  logic                zero_r, zero_nxt;
  logic [15:0]         newc_r, newc_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                rate_we;
  logic [RATE_W-1:0]   rate_wd;
  logic                count_we;
  logic [CIDX_W-1:0]   count_idx;
  logic [15:0]         count_wd;
  logic                load_we;
  logic [CIDX_W-1:0]   kidx;
  logic [4:0]          used_sum;
  logic [3:0]          used_now;
  logic signed [32:0]  dsub;
  logic [TOTAL_W-1:0]  cum_sum;
  logic [15:0]         cnt_rd;

  assign kidx     = k_r[CIDX_W-1:0];
  assign used_sum = {1'b0, cfg.active} + {2'b0, cfg.inactive};
  assign used_now = (used_sum > 5'(TABLE_CAP)) ? 4'(TABLE_CAP) : used_sum[3:0];
  assign dsub     = {y_r[31], y_r} - {mean_r[kidx][31], mean_r[kidx]};
  assign cum_sum  = cum_r + TOTAL_W'(rate_r[kidx]);
  assign cnt_rd   = count_r[count_idx];

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    used_nxt      = used_r;
    ad_nxt        = ad_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    thresh_nxt    = thresh_r;
    label_nxt     = label_r;
    zero_nxt      = zero_r;
    newc_nxt      = newc_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_take        = 1'b0;
    load_we       = 1'b0;
    rate_we       = 1'b0;
    rate_wd       = '0;
    count_we      = 1'b0;
    count_idx     = label_r[CIDX_W-1:0];
    count_wd      = '0;
    div_req       = '0;
    div_req.divisor = sigma_r[kidx];

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_item.action == ACT_LOAD) begin
            load_we = ({1'b0, q_item.entry_index} < 4'(TABLE_CAP));
          end else begin
            k_nxt     = '0;
            total_nxt = '0;
            used_nxt  = used_now;
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        if (k_r == used_r) begin
          state_nxt = ST_THRESH;
        end else if (sigma_r[kidx] == 32'd0) begin
          rate_we = 1'b1;
          k_nxt   = k_r + 1'b1;
        end else begin
          ad_nxt    = dsub[32] ? 33'(-dsub) : 33'(dsub);
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        // Beyond the table end: |d| >= 8 * sigma scores zero.
        if ({2'b0, ad_r} >= {sigma_r[kidx], 3'b0}) begin
          rate_we   = 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DIFF;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = {2'b0, ad_r[32:3]};
          div_req.bits  = {ad_r[2:0], {(DIV_BITS_W-3){1'b0}}};
          div_req.steps = DIV_CNT_W'(EXP_TABLE_BITS);
          state_nxt     = ST_IDX_WAIT;
        end
      end
      ST_IDX_WAIT: begin
        if (div_rsp.done) begin
          idx_nxt   = div_rsp.quotient[EXP_TABLE_BITS-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = 33'(weight_r[kidx]) * 33'(exp_tab[idx_r]);
        state_nxt = ST_RATE;
      end
      ST_RATE: begin
        div_req.start = 1'b1;
        div_req.rem0  = '0;
        div_req.bits  = {prod_r, 8'b0};
        div_req.steps = DIV_CNT_W'(DIV_BITS_W);
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_we   = 1'b1;
          rate_wd   = div_rsp.quotient;
          total_nxt = total_r + TOTAL_W'(div_rsp.quotient);
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_THRESH: begin
        thresh_nxt = THRESH_W'(draw_r) * THRESH_W'(total_r);
        zero_nxt   = (total_r == '0);
        k_nxt      = '0;
        cum_nxt    = '0;
        label_nxt  = 3'd0;
        state_nxt  = (total_r == '0) ? ST_DEC : ST_PICK;
      end
      ST_PICK: begin
        if (({cum_sum, 16'b0} >= thresh_r) || (k_r == used_r - 1'b1)) begin
          label_nxt = k_r[2:0];
          state_nxt = ST_DEC;
        end else begin
          cum_nxt = cum_sum;
          k_nxt   = k_r + 1'b1;
        end
      end
      ST_DEC: begin
        count_idx = old_r[CIDX_W-1:0];
        if (({1'b0, old_r} < 4'(TABLE_CAP)) && (cnt_rd != 16'd0)) begin
          count_we = 1'b1;
          count_wd = cnt_rd - 1'b1;
        end
        state_nxt = ST_INC;
      end
      ST_INC: begin
        count_we  = 1'b1;
        count_wd  = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 1'b1;
        newc_nxt  = count_wd;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.new_label       = label_r;
          out_nxt.new_label_count = newc_r;
          out_nxt.zero_total      = zero_r;
          out_nxt.sweep_done      = last_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      used_r      <= '0;
      for (int i = 0; i < TABLE_CAP; i++) count_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      used_r      <= used_nxt;
      if (load_we) count_r[q_item.entry_index[CIDX_W-1:0]] <= q_item.entry_count;
      else if (count_we) count_r[count_idx] <= count_wd;
    end
    if (load_we) begin
      weight_r[q_item.entry_index[CIDX_W-1:0]] <= q_item.entry_weight;
      mean_r[q_item.entry_index[CIDX_W-1:0]]   <= q_item.entry_mean;
      sigma_r[q_item.entry_index[CIDX_W-1:0]]  <= q_item.entry_sigma;
    end
    if (state_r == ST_IDLE && q_valid && q_item.action == ACT_SAMPLE) begin
      y_r    <= q_item.sample_value;
      old_r  <= q_item.old_label;
      draw_r <= q_item.uniform_draw;
      last_r <= q_item.last_sample;
    end
    if (rate_we) rate_r[kidx] <= rate_wd;
    ad_r     <= ad_nxt;
    idx_r    <= idx_nxt;
    prod_r   <= prod_nxt;
    total_r  <= total_nxt;
    cum_r    <= cum_nxt;
    thresh_r <= thresh_nxt;
    label_r  <= label_nxt;
    zero_r   <= zero_nxt;
    newc_r   <= newc_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/gaussian_mixture_label_sampler.sv
// ----------------------------------------------------------------------------
// gaussian_mixture_label_sampler
// One Gibbs label step for a one-dimensional Gaussian mixture in fixed point.
//
//   Channel  Ports                          Beat
//   in       in_valid / in_ready / in_data  load one entry or sample one label
//   out      out_valid / out_ready / out_data  one result per sample beat
//   cfg      cfg_we / cfg_index / cfg_wdata    component counts, no wait
//
// A load beat is written to the table as it leaves the queue. A sample beat
// uses the one-bit-per-cycle divider to form each table index and each rate,
// and the engine takes no new beat until the sample beat has finished.
// Reset is synchronous, active low; label counts clear, the active count is 1.
// A two-beat queue accepts input until full while a result waits on out_ready.
// ----------------------------------------------------------------------------
`include "gaussian_mixture_label_sampler_macros.svh"

module gaussian_mixture_label_sampler #(
  parameter int MAX_COMPONENTS = 8,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gmls_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gmls_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_wdata
);
  import gmls_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      q_valid;
  in_item_t  q_item;
  logic      q_take;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE:   cfg_nxt.active   = cfg_wdata;
        CFG_INACTIVE: cfg_nxt.inactive = cfg_wdata[2:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active   <= 4'd1;
      cfg_r.inactive <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gmls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  gmls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gmls_back #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `GMLS_ASSERT_SAME(a_take_needs_item, q_take, q_valid, "queue popped while empty")
  `GMLS_ASSERT_SAME(a_full_stalls_input, !in_ready, q_valid, "input stalled with empty queue")
  `GMLS_ASSERT_SAME(a_zero_total_label, out_valid && out_data.zero_total, out_data.new_label == 3'd0, "zero total without label zero")
  `GMLS_ASSERT_NEXT(a_div_start_idle, div_req.start, !div_req.start, "divider restarted back to back")

endmodule
